>>> hw/rtl/logistic_loss_gradient_accumulator_macros.svh
// Assertion macros for the logistic loss gradient accumulator.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef LOGISTIC_LOSS_GRADIENT_ACCUMULATOR_MACROS_SVH
`define LOGISTIC_LOSS_GRADIENT_ACCUMULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LLGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LLGA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LLGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LLGA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/llga_pkg.sv
// Package for the logistic loss gradient accumulator: op codes, state type,
// default sizes and fixed-point constants. No dependencies.
`default_nettype none
package llga_pkg;
    localparam int WEIGHT_COUNT_DEF   = 256;
    localparam int SAMPLE_ENTRIES_DEF = 64;
    localparam int SIG_TABLE_DEF      = 4096;

    localparam int GRAD_W  = 48;
    localparam int LOSS_W  = 48;
    localparam int COUNT_W = 32;
    localparam int SCORE_W = 32;
    localparam int A_W     = 35;

    localparam logic [15:0]        ONE_Q15   = 16'd32768;
    localparam logic [15:0]        GAIN_RST  = 16'd32768;
    localparam logic signed [48:0] ARG_LIM   = 49'sd134217728;
    localparam logic signed [48:0] GRAD_MAXV = 49'sd140737488355327;
    localparam logic signed [48:0] GRAD_MINV = -49'sd140737488355328;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FEAT  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FEAT,
        ST_READ,
        ST_ARG,
        ST_IDX,
        ST_ADDR,
        ST_ROM,
        ST_DIFF,
        ST_MUL,
        ST_PROD,
        ST_WBUF,
        ST_WGRAD,
        ST_WWR,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

>>> hw/rtl/llga_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module llga_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/logistic_loss_gradient_accumulator.sv
// Logistic loss gradient accumulator. Load, clear and config writes complete as
// they are accepted. A read waits, if need be, for the previous result to leave
// the output register. A feature item passes through the feature state. A
// closing feature item then runs the sigmoid and loss path, a read-modify-write
// walk over the sample buffer and gradient memory for each buffered element,
// and a finishing step. Weights and gradients sit in RAMs with per-entry valid
// bits, so reset and clear take effect at once. The sigmoid table is a ROM
// built at elaboration. Depends on llga_pkg, llga_ram and the macro header.
`default_nettype none
`include "logistic_loss_gradient_accumulator_macros.svh"
module logistic_loss_gradient_accumulator
    import llga_pkg::*;
#(
    parameter int WEIGHT_COUNT       = WEIGHT_COUNT_DEF,
    parameter int SAMPLE_ENTRIES     = SAMPLE_ENTRIES_DEF,
    parameter int SIGMOID_TABLE_SIZE = SIG_TABLE_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data,      // gain_k
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,    // index, weight_value, feature_value, target
    input  wire logic [1:0]   s_axis_tuser,    // op
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [135:0]      m_axis_tdata     // gradient_sum, loss_sum, sample_count, overflow
);
    localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
    localparam int BW = (SAMPLE_ENTRIES > 1) ? $clog2(SAMPLE_ENTRIES) : 1;
    localparam int LW = $clog2(SAMPLE_ENTRIES + 1);
    localparam int RW = $clog2(SIGMOID_TABLE_SIZE);

    typedef logic [15:0] t_rom [SIGMOID_TABLE_SIZE];

    function automatic longint unsigned rom_div(longint unsigned num, longint unsigned dvs);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 46; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= dvs) begin
                rem = rem - dvs;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_rom build_rom();
        t_rom              tbl;
        longint            xq;
        longint            mag;
        longint            sum;
        longint unsigned   z;
        longint unsigned   term;
        longint unsigned   p;
        longint unsigned   den;
        longint unsigned   pos;
        for (int i = 0; i < SIGMOID_TABLE_SIZE; i++) begin
            xq = ((longint'(i) <<< 28) / SIGMOID_TABLE_SIZE) - (longint'(1) <<< 27);
            mag = (xq < 0) ? -xq : xq;
            z = longint'(unsigned'(mag) << 2);
            sum = longint'(1) <<< 30;
            term = longint'(1) <<< 30;
            for (int k = 1; k <= 20; k++) begin
                term = rom_div((term * z) >> 30, longint'(unsigned'(k)));
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            p = longint'(unsigned'(sum));
            for (int k = 0; k < 4; k++) begin
                p = (p * p + (64'd1 << 29)) >> 30;
            end
            den = (64'd1 << 30) + p;
            pos = rom_div((64'd1 << 45) + (den >> 1), den);
            if (xq < 0) begin
                pos = 64'd32768 - pos;
            end
            tbl[i] = pos[15:0];
        end
        return tbl;
    endfunction

    localparam t_rom SIG_ROM = build_rom();

    // input unpacking
    logic        w_acc;
    t_op         w_op;
    logic [7:0]  w_in_idx;
    logic [15:0] w_in_w;
    logic [4:0]  w_in_fv;
    logic [15:0] w_in_tgt;
    logic        w_in_rng;

    assign w_acc    = s_axis_tvalid && s_axis_tready;
    assign w_op     = t_op'(s_axis_tuser);
    assign w_in_idx = s_axis_tdata[7:0];
    assign w_in_w   = s_axis_tdata[23:8];
    assign w_in_fv  = s_axis_tdata[28:24];
    assign w_in_tgt = s_axis_tdata[44:29];
    assign w_in_rng = ({1'b0, w_in_idx} < 9'(WEIGHT_COUNT));

    t_state r_state, n_state;

    logic [15:0]               r_gain;
    logic [7:0]                r_idx;
    logic signed [4:0]         r_fv;
    logic [15:0]               r_tgt;
    logic                      r_last;
    logic                      r_rng;
    logic                      r_wvrd;
    logic                      r_gvrd;
    logic [WEIGHT_COUNT-1:0]   r_w_vld;
    logic [WEIGHT_COUNT-1:0]   r_g_vld;
    logic [LW-1:0]             r_len;
    logic [LW-1:0]             r_j;
    logic signed [SCORE_W-1:0] r_score;
    logic signed [48:0]        r_arg;
    logic [28:0]               r_u;
    logic [RW-1:0]             r_rom_addr;
    logic [15:0]               r_sig;
    logic signed [16:0]        r_d;
    logic [33:0]               r_sq;
    logic signed [32:0]        r_ds;
    logic signed [A_W-1:0]     r_a;
    logic [AW-1:0]             r_gidx;
    logic signed [4:0]         r_cnt;
    logic [LOSS_W-1:0]         r_loss;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_sat;
    logic                      r_m_valid;
    logic [135:0]              r_m_data;

    // RAM ports
    logic              w_wt_we, w_wt_re;
    logic [AW-1:0]     w_wt_waddr, w_wt_raddr;
    logic [15:0]       w_wt_rdata;
    logic              w_gr_we, w_gr_re;
    logic [AW-1:0]     w_gr_waddr, w_gr_raddr;
    logic [GRAD_W-1:0] w_gr_wdata, w_gr_rdata;
    logic              w_bf_we, w_bf_re;
    logic [BW-1:0]     w_bf_waddr, w_bf_raddr;
    logic [12:0]       w_bf_wdata, w_bf_rdata;
    logic [AW-1:0]     w_bf_gidx;

    assign w_bf_gidx = w_bf_rdata[5 +: AW];

    logic w_out_free;
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && w_op == OP_FEAT) begin
                    n_state = ST_FEAT;
                end else if (w_acc && w_op == OP_READ) begin
                    n_state = ST_READ;
                end
            end
            ST_FEAT:  n_state = r_last ? ST_ARG : ST_IDLE;
            ST_READ:  n_state = w_out_free ? ST_IDLE : ST_READ;
            ST_ARG:   n_state = ST_IDX;
            ST_IDX:   n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_ROM;
            ST_ROM:   n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_PROD;
            ST_PROD:  n_state = ST_WBUF;
            ST_WBUF:  n_state = (r_j == r_len) ? ST_DONE : ST_WGRAD;
            ST_WGRAD: n_state = ST_WWR;
            ST_WWR:   n_state = ST_WBUF;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_wt_we    = w_acc && w_op == OP_LOAD && w_in_rng;
        w_wt_waddr = w_in_idx[AW-1:0];
        w_wt_re    = w_acc && w_op == OP_FEAT;
        w_wt_raddr = w_in_idx[AW-1:0];
        w_bf_we    = (r_state == ST_FEAT) && r_rng && (r_len != LW'(SAMPLE_ENTRIES));
        w_bf_waddr = r_len[BW-1:0];
        w_bf_wdata = {r_idx, r_fv};
        w_bf_re    = (r_state == ST_WBUF) && (r_j != r_len);
        w_bf_raddr = r_j[BW-1:0];
        w_gr_re    = (w_acc && w_op == OP_READ) || (r_state == ST_WGRAD);
        w_gr_raddr = (r_state == ST_WGRAD) ? w_bf_gidx : w_in_idx[AW-1:0];
        w_gr_we    = (r_state == ST_WWR);
        w_gr_waddr = r_gidx;
    end

    // datapath
    logic signed [15:0]     w_wv;
    logic signed [20:0]     w_fprod;
    logic signed [32:0]     w_ssum;
    logic                   w_shi, w_slo;
    logic signed [48:0]     w_arg;
    logic [43:0]            w_scaled;
    logic [15:0]            w_ridx;
    logic signed [33:0]     w_sq;
    logic signed [32:0]     w_ds;
    logic [16:0]            w_oms;
    logic signed [50:0]     w_p;
    logic [LOSS_W:0]        w_lsum;
    logic signed [39:0]     w_gprod;
    logic signed [GRAD_W-1:0] w_gold;
    logic signed [48:0]     w_gsum;
    logic                   w_ghi, w_glo;

    always_comb begin
        w_wv     = r_wvrd ? $signed(w_wt_rdata) : 16'sd0;
        w_fprod  = r_fv * w_wv;
        w_ssum   = 33'(r_score) + 33'(w_fprod);
        w_shi    = w_ssum > 33'sd2147483647;
        w_slo    = w_ssum < -33'sd2147483648;
        w_arg    = $signed({1'b0, r_gain}) * r_score;
        w_scaled = 44'(r_u) * 44'(SIGMOID_TABLE_SIZE);
        w_ridx   = w_scaled[43:28];
        w_sq     = r_d * r_d;
        w_ds     = r_d * $signed({1'b0, r_sig});
        w_oms    = {1'b0, ONE_Q15} - {1'b0, r_sig};
        w_p      = r_ds * $signed({1'b0, w_oms});
        w_lsum   = {1'b0, r_loss} + (LOSS_W + 1)'(r_sq);
        w_gprod  = r_a * r_cnt;
        w_gold   = r_gvrd ? $signed(w_gr_rdata) : '0;
        w_gsum   = 49'(w_gold) + 49'(w_gprod);
        w_ghi    = w_gsum > GRAD_MAXV;
        w_glo    = w_gsum < GRAD_MINV;
        if (w_ghi) begin
            w_gr_wdata = GRAD_MAXV[GRAD_W-1:0];
        end else if (w_glo) begin
            w_gr_wdata = GRAD_MINV[GRAD_W-1:0];
        end else begin
            w_gr_wdata = w_gsum[GRAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gain    <= GAIN_RST;
            r_w_vld   <= '0;
            r_g_vld   <= '0;
            r_len     <= '0;
            r_j       <= '0;
            r_score   <= '0;
            r_loss    <= '0;
            r_count   <= '0;
            r_sat     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
            if (r_state == ST_READ && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_acc) begin
                r_idx  <= w_in_idx;
                r_fv   <= $signed(w_in_fv);
                r_tgt  <= (w_in_tgt > ONE_Q15) ? ONE_Q15 : w_in_tgt;
                r_last <= s_axis_tlast;
                r_rng  <= w_in_rng;
                r_wvrd <= r_w_vld[w_in_idx[AW-1:0]];
                r_gvrd <= r_g_vld[w_in_idx[AW-1:0]];
                case (w_op)
                    OP_LOAD: begin
                        if (w_in_rng) begin
                            r_w_vld[w_in_idx[AW-1:0]] <= 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        r_g_vld <= '0;
                        r_loss  <= '0;
                        r_count <= '0;
                        r_sat   <= 1'b0;
                        r_score <= '0;
                        r_len   <= '0;
                    end
                    default: ;
                endcase
            end
            case (r_state)
                ST_FEAT: begin
                    if (r_rng) begin
                        if (w_shi) begin
                            r_score <= 32'sh7FFFFFFF;
                        end else if (w_slo) begin
                            r_score <= 32'sh80000000;
                        end else begin
                            r_score <= w_ssum[31:0];
                        end
                        if (r_len != LW'(SAMPLE_ENTRIES)) begin
                            r_len <= r_len + 1'b1;
                        end
                        if (w_shi || w_slo || (r_len == LW'(SAMPLE_ENTRIES))) begin
                            r_sat <= 1'b1;
                        end
                    end
                end
                ST_READ: begin
                    if (w_out_free) begin
                        r_m_data  <= {7'd0, r_sat, r_count, r_loss,
                                      (r_rng && r_gvrd) ? w_gr_rdata : {GRAD_W{1'b0}}};
                    end
                end
                ST_ARG: r_arg <= w_arg;
                ST_IDX: begin
                    if (r_arg > ARG_LIM) begin
                        r_u <= 29'd268435456;
                    end else if (r_arg < -ARG_LIM) begin
                        r_u <= '0;
                    end else begin
                        r_u <= 29'(r_arg + ARG_LIM);
                    end
                end
                ST_ADDR: begin
                    if (w_ridx > 16'(SIGMOID_TABLE_SIZE - 1)) begin
                        r_rom_addr <= RW'(SIGMOID_TABLE_SIZE - 1);
                    end else begin
                        r_rom_addr <= w_ridx[RW-1:0];
                    end
                end
                ST_ROM:  r_sig <= SIG_ROM[r_rom_addr];
                ST_DIFF: r_d <= $signed({1'b0, r_tgt}) - $signed({1'b0, r_sig});
                ST_MUL: begin
                    r_sq <= w_sq[33:0];
                    r_ds <= w_ds;
                end
                ST_PROD: begin
                    r_a <= A_W'(w_p >>> 15);
                    r_j <= '0;
                    if (w_lsum[LOSS_W]) begin
                        r_loss <= {LOSS_W{1'b1}};
                        r_sat  <= 1'b1;
                    end else begin
                        r_loss <= w_lsum[LOSS_W-1:0];
                    end
                end
                ST_WGRAD: begin
                    r_gidx <= w_bf_gidx;
                    r_cnt  <= $signed(w_bf_rdata[4:0]);
                    r_gvrd <= r_g_vld[w_bf_gidx];
                end
                ST_WWR: begin
                    r_g_vld[r_gidx] <= 1'b1;
                    r_j <= r_j + 1'b1;
                    if (w_ghi || w_glo) begin
                        r_sat <= 1'b1;
                    end
                end
                ST_DONE: begin
                    if (r_count == {COUNT_W{1'b1}}) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    r_score <= '0;
                    r_len   <= '0;
                end
                default: ;
            endcase
        end
    end

    llga_ram #(.WIDTH(16), .DEPTH(WEIGHT_COUNT)) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_wt_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (w_in_w),
        .i_re    (w_wt_re),
        .i_raddr (w_wt_raddr),
        .o_rdata (w_wt_rdata)
    );

    llga_ram #(.WIDTH(GRAD_W), .DEPTH(WEIGHT_COUNT)) u_gradients (
        .i_clk   (i_clk),
        .i_we    (w_gr_we),
        .i_waddr (w_gr_waddr),
        .i_wdata (w_gr_wdata),
        .i_re    (w_gr_re),
        .i_raddr (w_gr_raddr),
        .o_rdata (w_gr_rdata)
    );

    llga_ram #(.WIDTH(13), .DEPTH(SAMPLE_ENTRIES)) u_sample_buf (
        .i_clk   (i_clk),
        .i_we    (w_bf_we),
        .i_waddr (w_bf_waddr),
        .i_wdata (w_bf_wdata),
        .i_re    (w_bf_re),
        .i_raddr (w_bf_raddr),
        .o_rdata (w_bf_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `LLGA_ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, r_state == ST_WWR, r_j < r_len,
        "gradient walk past buffered length")
    `LLGA_ASSERT_IMP(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(SAMPLE_ENTRIES),
        "sample length beyond buffer depth")
    `LLGA_ASSERT_NXT(a_clear, i_clk, i_rst_n, w_acc && w_op == OP_CLEAR,
        r_g_vld == '0 && r_loss == '0 && r_count == '0, "clear item left sums")
    `LLGA_ASSERT_NXT(a_close, i_clk, i_rst_n, r_state == ST_FEAT && r_last,
        r_state == ST_ARG, "closing item did not start sigmoid path")
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for logistic_loss_gradient_accumulator: a scoreboard
// class predicts every read item from its own fixed-point model of the block.
// Depends on llga_pkg and the RTL top level only.
`timescale 1ns / 1ps
module testbench;
    import llga_pkg::*;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  index;
        logic [15:0] weight;
        logic [4:0]  feature;
        logic [15:0] target;
        logic        last;
    } t_item;

    typedef struct packed {
        logic        overflow;
        logic [31:0] count;
        logic [47:0] loss;
        logic [47:0] grad;
    } t_sums;

    class sums_scoreboard;
        logic [15:0]       sig_rom [4096];
        logic [15:0]       gain;
        shortint           weights [256];
        byte unsigned      buf_idx [64];
        byte               buf_cnt [64];
        int                buf_len;
        int                score;
        longint            grad [256];
        longint unsigned   loss;
        int unsigned       done;
        bit                sat;
        t_sums             expected_sums [$];
        int                errors;
        int                reads_checked;
        int                samples_closed;

        function new();
            for (int i = 0; i < 4096; i++) sig_rom[i] = sigmoid_entry(i);
            gain = GAIN_RST;
            foreach (weights[i]) weights[i] = 0;
            buf_len = 0;
            score = 0;
            foreach (grad[i]) grad[i] = 0;
            loss = 0;
            done = 0;
            sat = 0;
            errors = 0;
            reads_checked = 0;
            samples_closed = 0;
        endfunction

        static function logic [15:0] sigmoid_entry(int unsigned i);
            longint          xq;
            longint          mag;
            longint unsigned z;
            longint          sum;
            longint unsigned term;
            longint unsigned p;
            longint unsigned den;
            longint unsigned pos;
            xq = longint'((longint'(i) << 28) / 4096) - (longint'(1) << 27);
            mag = xq < 0 ? -xq : xq;
            z = longint'(mag << 6) >> 4;
            sum = longint'(1) << 30;
            term = longint'(1) << 30;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * z) >> 30) / k;
                if (k & 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            p = sum;
            for (int k = 0; k < 4; k++) p = (p * p + (64'd1 << 29)) >> 30;
            den = (64'd1 << 30) + p;
            pos = ((64'd1 << 45) + den / 2) / den;
            if (xq < 0) pos = 32768 - pos;
            return pos[15:0];
        endfunction

        function void finish_sample(logic [15:0] target_raw);
            longint          arg;
            longint unsigned idx;
            longint          s;
            longint          d;
            longint          a;
            longint          g;
            longint unsigned sq;
            longint unsigned tgt;
            arg = longint'(gain) * longint'(score);
            if (arg > 134217728) arg = 134217728;
            if (arg < -134217728) arg = -134217728;
            idx = (longint'(arg + 134217728) * 4096) >> 28;
            if (idx > 4095) idx = 4095;
            s = sig_rom[idx];
            tgt = target_raw > 32768 ? 32768 : target_raw;
            d = longint'(tgt) - s;
            sq = d * d;
            if (loss > (64'd1 << 48) - 1 - sq) begin
                loss = (64'd1 << 48) - 1;
                sat = 1;
            end else begin
                loss += sq;
            end
            a = (d * s * (32768 - s)) >>> 15;
            for (int j = 0; j < buf_len; j++) begin
                g = grad[buf_idx[j]] + a * longint'(buf_cnt[j]);
                if (g > GRAD_MAXV) begin
                    g = GRAD_MAXV;
                    sat = 1;
                end
                if (g < GRAD_MINV) begin
                    g = GRAD_MINV;
                    sat = 1;
                end
                grad[buf_idx[j]] = g;
            end
            if (done == 32'hFFFF_FFFF) sat = 1;
            else done++;
            score = 0;
            buf_len = 0;
            samples_closed++;
        endfunction

        function void note_input(t_item it);
            longint sc;
            t_sums  r;
            case (t_op'(it.op))
                OP_LOAD: weights[it.index] = it.weight;
                OP_FEAT: begin
                    sc = longint'(score)
                        + longint'($signed(it.feature)) * longint'(weights[it.index]);
                    if (sc > 64'sd2147483647) begin
                        sc = 64'sd2147483647;
                        sat = 1;
                    end
                    if (sc < -64'sd2147483648) begin
                        sc = -64'sd2147483648;
                        sat = 1;
                    end
                    score = int'(sc);
                    if (buf_len < 64) begin
                        buf_idx[buf_len] = it.index;
                        buf_cnt[buf_len] = byte'($signed(it.feature));
                        buf_len++;
                    end else begin
                        sat = 1;
                    end
                    if (it.last) finish_sample(it.target);
                end
                OP_READ: begin
                    r.grad = grad[it.index][47:0];
                    r.loss = loss[47:0];
                    r.count = done;
                    r.overflow = sat;
                    expected_sums = {expected_sums, r};
                end
                default: begin
                    foreach (grad[i]) grad[i] = 0;
                    loss = 0;
                    done = 0;
                    sat = 0;
                    score = 0;
                    buf_len = 0;
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [47:0] got, logic [47:0] want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [135:0] data);
            t_sums got;
            t_sums want;
            got = data[128:0];
            if (expected_sums.size() == 0) begin
                report_mismatch("unexpected read item", got.grad, '0);
                return;
            end
            want = expected_sums.pop_front();
            reads_checked++;
            if (got.grad !== want.grad) report_mismatch("gradient_sum", got.grad, want.grad);
            if (got.loss !== want.loss) report_mismatch("loss_sum", got.loss, want.loss);
            if (got.count !== want.count) report_mismatch("sample_count", got.count, want.count);
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", got.overflow, want.overflow);
        endtask
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [135:0] m_axis_tdata;

    sums_scoreboard sb = new();
    int             burst_left = 0;
    int             stall_mode = 0;
    int             stall_left = 0;
    int             gains_used = 0;

    logistic_loss_gradient_accumulator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 0);
            2: m_axis_tready <= ($urandom_range(0, 9) == 0);
            default: m_axis_tready <= (stall_left % 16) < 8;
        endcase
    end

    task send_item(t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tuser <= it.op;
        s_axis_tlast <= it.last;
        s_axis_tdata <= {3'b0, it.target, it.feature, it.weight, it.index};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(it);
    endtask

    task send_op(t_op op, int idx, int w, int f, int tgt, bit last);
        t_item it;
        it.op = op;
        it.index = idx[7:0];
        it.weight = w[15:0];
        it.feature = f[4:0];
        it.target = tgt[15:0];
        it.last = last;
        send_item(it);
    endtask

    task send_random(t_op op, bit last);
        send_op(op, $urandom_range(0, 255), $urandom, $urandom, $urandom, last);
    endtask

    task drain();
        s_axis_tvalid <= 0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.expected_sums.size() != 0);
        repeat (250) @(posedge i_clk);
    endtask

    task write_gain(logic [15:0] g);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.gain = g;
        gains_used++;
        i_cfg_valid <= 0;
    endtask

    task random_sample(int len);
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 19) == 0) send_random(OP_READ, 0);
            send_op(OP_FEAT, $urandom_range(0, 31), $urandom, $urandom, $urandom_range(0, 9) == 0
                ? $urandom : $urandom_range(0, 32768), j == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_op(OP_LOAD, 0, 32767, 0, 0, 0);
        send_op(OP_LOAD, 255, -32768, 0, 0, 0);
        send_op(OP_LOAD, 7, 256, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_FEAT, 0, 0, 15, 0, 1);
        send_op(OP_FEAT, 255, 0, -16, 65535, 0);
        send_op(OP_FEAT, 7, 0, 3, 32768, 1);
        send_op(OP_FEAT, 7, 0, 0, 32768, 0);
        send_op(OP_FEAT, 7, 0, 1, 12345, 1);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_READ, 255, 0, 0, 0, 0);
        send_op(OP_READ, 7, 0, 0, 0, 0);
        send_op(OP_FEAT, 0, 0, 5, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_FEAT, 0, 0, 2, 0, 1);
        send_op(OP_READ, 0, 0, 0, 0, 0);

        // overrun the sample buffer in one long sample with the argument clamped high
        write_gain(16'd65535);
        send_op(OP_LOAD, 1, 32767, 0, 0, 0);
        for (int j = 0; j < 70; j++) send_op(OP_FEAT, 1, 0, 15, 0, j == 69);
        send_op(OP_READ, 1, 0, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_gain(16'd0);
                1: write_gain(16'd32768);
                2: write_gain(16'd65535);
                default: write_gain(16'($urandom));
            endcase
            for (int j = 0; j < 20; j++) send_random(OP_LOAD, 0);
            for (int n = 0; n < 18; n++) begin
                case ($urandom_range(0, 19))
                    0: send_random(OP_CLEAR, 0);
                    1, 2: send_random(OP_LOAD, 0);
                    3: send_random(OP_FEAT, $urandom_range(0, 1));
                    4: random_sample(65 + $urandom_range(0, 5));
                    default: begin
                        len = $urandom_range(1, 8);
                        random_sample(len);
                    end
                endcase
                send_op(OP_READ, $urandom_range(0, 31), $urandom, $urandom, $urandom,
                    $urandom_range(0, 1));
                if (n == 15) drain();
            end
        end

        drain();
        $display("run covered %0d gain settings, %0d closed samples, %0d reads checked",
            gains_used, sb.samples_closed, sb.reads_checked);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
